[sv/dtit_pkg.sv]
package dtit_pkg;

	localparam int MAX_LEAVES = 1024;
	localparam int CNT_W      = $clog2(MAX_LEAVES) + 1;
	localparam int POS_W      = $clog2(MAX_LEAVES);

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_MERGE = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic accept;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic has_result;
	} dp_stat_t;

	// magnitude of a two's complement child reference
	function automatic logic [CNT_W-1:0] child_mag(input logic [CNT_W-1:0] c);
		child_mag = c[CNT_W-1] ? (~c + CNT_W'(1)) : c;
	endfunction

endpackage

[sv/dtit_if.sv]
interface dtit_in_if;
	import dtit_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic [CNT_W-1:0]        leaf_id;
	logic signed [CNT_W-1:0] child_first;
	logic signed [CNT_W-1:0] child_second;

	modport source (output valid, mode, leaf_id, child_first, child_second, input ready);
	modport sink   (input valid, mode, leaf_id, child_first, child_second, output ready);
endinterface

interface dtit_out_if;
	import dtit_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] pos_low;
	logic [CNT_W-1:0] pos_split;
	logic [CNT_W-1:0] pos_high;
	logic             last_merge;
	logic             bad_child;

	modport source (output valid, pos_low, pos_split, pos_high, last_merge, bad_child,
		input ready);
	modport sink   (input valid, pos_low, pos_split, pos_high, last_merge, bad_child,
		output ready);
endinterface

[sv/dtit_ctrl.sv]
module dtit_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dtit_pkg::dp_cmd_t cmd,
	input  dtit_pkg::dp_stat_t stat
);
	import dtit_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic stall;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.accept = in_valid && in_ready;
	// hold in EXEC while the previous result word still sits unread
	assign stall      = stat.has_result && out_valid_q && !out_ready;
	assign cmd.commit = (state_q == ST_EXEC) && !stall;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.commit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit && stat.has_result)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[sv/dtit_dp.sv]
module dtit_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic        [dtit_pkg::CNT_W-1:0]     cfg_wr_data,
	input  logic        [1:0]                     mode,
	input  logic        [dtit_pkg::CNT_W-1:0]     leaf_id,
	input  logic signed [dtit_pkg::CNT_W-1:0]     child_first,
	input  logic signed [dtit_pkg::CNT_W-1:0]     child_second,
	input  dtit_pkg::dp_cmd_t                     cmd,
	output dtit_pkg::dp_stat_t                    stat,
	output logic        [dtit_pkg::CNT_W-1:0]     pos_low,
	output logic        [dtit_pkg::CNT_W-1:0]     pos_split,
	output logic        [dtit_pkg::CNT_W-1:0]     pos_high,
	output logic                                  last_merge,
	output logic                                  bad_child
);
	import dtit_pkg::*;

	logic [POS_W-1:0] leaf_rank_mem  [MAX_LEAVES];
	logic [POS_W-1:0] merge_low_mem  [MAX_LEAVES-1];
	logic [POS_W-1:0] merge_high_mem [MAX_LEAVES-1];

	logic [CNT_W-1:0] leaf_count_q;
	logic [CNT_W-1:0] order_pos_q;
	logic [POS_W-1:0] merge_pos_q;

	logic [1:0]       mode_q;
	logic [CNT_W-1:0] leaf_id_q;
	logic [CNT_W-1:0] cf_q, cs_q;

	logic [POS_W-1:0] rank_f_q, rank_s_q, low_f_q, low_s_q, high_f_q, high_s_q;

	logic [CNT_W-1:0] down_q, split_q, up_q;
	logic             last_q, bad_q;

	logic [CNT_W-1:0] addr_f_w, addr_s_w, leaf_addr_w;
	logic [CNT_W-1:0] n_eff, n_m1, n_m2, mag_f, mag_s, merge_pos_x;
	logic             ok_f, ok_s, bad, merge_room, load_ok, rank_we, merge_we;
	logic [POS_W-1:0] lo_f, hi_f, lo_s, hi_s, down, split, up;

	// read addresses straight from the incoming word
	assign addr_f_w = child_mag(child_first) - CNT_W'(1);
	assign addr_s_w = child_mag(child_second) - CNT_W'(1);

	always_comb begin
		if (leaf_count_q < CNT_W'(2))
			n_eff = CNT_W'(2);
		else if (leaf_count_q > CNT_W'(MAX_LEAVES))
			n_eff = CNT_W'(MAX_LEAVES);
		else
			n_eff = leaf_count_q;
	end

	assign n_m1        = n_eff - CNT_W'(1);
	assign n_m2        = n_eff - CNT_W'(2);
	assign merge_pos_x = {1'b0, merge_pos_q};
	assign mag_f       = child_mag(cf_q);
	assign mag_s       = child_mag(cs_q);

	assign ok_f = cf_q[CNT_W-1] ? (mag_f <= n_eff) : (cf_q != '0 && mag_f <= merge_pos_x);
	assign ok_s = cs_q[CNT_W-1] ? (mag_s <= n_eff) : (cs_q != '0 && mag_s <= merge_pos_x);
	assign bad  = !(ok_f && ok_s);

	assign lo_f = cf_q[CNT_W-1] ? rank_f_q : low_f_q;
	assign hi_f = cf_q[CNT_W-1] ? rank_f_q : high_f_q;
	assign lo_s = cs_q[CNT_W-1] ? rank_s_q : low_s_q;
	assign hi_s = cs_q[CNT_W-1] ? rank_s_q : high_s_q;

	assign down  = (lo_f < lo_s) ? lo_f : lo_s;
	assign split = (hi_f < hi_s) ? hi_f : hi_s;
	assign up    = (hi_f > hi_s) ? hi_f : hi_s;

	assign merge_room      = merge_pos_x < n_m1;
	assign stat.has_result = (mode_q == MODE_MERGE) && merge_room;
	assign merge_we        = cmd.commit && stat.has_result && !bad;

	assign load_ok     = (mode_q == MODE_LOAD) && (order_pos_q < n_eff);
	assign rank_we     = cmd.commit && load_ok && leaf_id_q != '0 && leaf_id_q <= n_eff;
	assign leaf_addr_w = leaf_id_q - CNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q    <= mode;
			leaf_id_q <= leaf_id;
			cf_q      <= child_first;
			cs_q      <= child_second;
			rank_f_q  <= leaf_rank_mem[addr_f_w[POS_W-1:0]];
			rank_s_q  <= leaf_rank_mem[addr_s_w[POS_W-1:0]];
			low_f_q   <= merge_low_mem[addr_f_w[POS_W-1:0]];
			low_s_q   <= merge_low_mem[addr_s_w[POS_W-1:0]];
			high_f_q  <= merge_high_mem[addr_f_w[POS_W-1:0]];
			high_s_q  <= merge_high_mem[addr_s_w[POS_W-1:0]];
		end
		if (rank_we)
			leaf_rank_mem[leaf_addr_w[POS_W-1:0]] <= order_pos_q[POS_W-1:0];
		if (merge_we) begin
			merge_low_mem[merge_pos_q]  <= down;
			merge_high_mem[merge_pos_q] <= up;
		end
		if (cmd.commit && stat.has_result) begin
			bad_q   <= bad;
			down_q  <= bad ? '0 : {1'b0, down} + CNT_W'(1);
			split_q <= bad ? '0 : {1'b0, split} + CNT_W'(1);
			up_q    <= bad ? '0 : {1'b0, up} + CNT_W'(1);
			last_q  <= !bad && (merge_pos_x == n_m2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= CNT_W'(MAX_LEAVES);
			order_pos_q  <= '0;
			merge_pos_q  <= '0;
		end else begin
			if (cfg_wr_en)
				leaf_count_q <= cfg_wr_data;
			if (cmd.commit && mode_q == MODE_CLEAR) begin
				order_pos_q <= '0;
				merge_pos_q <= '0;
			end else begin
				if (cmd.commit && load_ok)
					order_pos_q <= order_pos_q + CNT_W'(1);
				if (merge_we)
					merge_pos_q <= merge_pos_q + POS_W'(1);
			end
		end
	end

	assign pos_low    = down_q;
	assign pos_split  = split_q;
	assign pos_high   = up_q;
	assign last_merge = last_q;
	assign bad_child  = bad_q;

endmodule

[sv/dendrogram_to_interval_tree.sv]
// Dendrogram to interval tree converter. Mode 0 words load leaf ids in display order,
// mode 1 words carry one merge row and, while fewer than leaf_count - 1 merges are
// stored, give one result word (down, split and up positions, 1-based, or bad_child
// with zeros), mode 2 restarts the counters for a new tree, mode 3 is ignored. Taking
// a word issues registered reads of the rank and merge tables for both children; the
// EXEC state then resolves the children and writes back the merge interval, so a row
// may refer to the merge just before it. A result waiting at the output holds a word
// with a result in EXEC until it is taken. The tables come up undefined after reset
// and need no clearing pass; leaf_count may only be changed while no word is in flight.
module dendrogram_to_interval_tree (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dtit_pkg::CNT_W-1:0]  cfg_wr_data,
	dtit_in_if.sink                     in_ch,
	dtit_out_if.source                  out_ch
);
	import dtit_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dtit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	dtit_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.mode         (in_ch.mode),
		.leaf_id      (in_ch.leaf_id),
		.child_first  (in_ch.child_first),
		.child_second (in_ch.child_second),
		.cmd          (cmd),
		.stat         (stat),
		.pos_low      (out_ch.pos_low),
		.pos_split    (out_ch.pos_split),
		.pos_high     (out_ch.pos_high),
		.last_merge   (out_ch.last_merge),
		.bad_child    (out_ch.bad_child)
	);

`ifndef SYNTHESIS
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && stat.has_result |=> out_ch.valid)
		else $error("result word not presented after commit");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ch.ready)
		else $error("new word taken while one is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && out_ch.valid && !out_ch.ready |-> !stat.has_result)
		else $error("pending result word overwritten");
`endif

endmodule
